FILE: rtl/llrc_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// llrc_pkg
// Shared types, codes and reset values of the lease lifecycle retry controller.
// ---------------------------------------------------------------------------
package llrc_pkg;

    localparam int LEASE_SLOTS_DEF = 16;
    localparam int TIME_BITS_DEF   = 32;

    localparam logic [23:0] KEEP_ALIVE_DEF  = 24'd60000;
    localparam logic [23:0] START_TO_DEF    = 24'd15000;
    localparam logic [23:0] QUIESCE_TO_DEF  = 24'd5000;
    localparam logic [23:0] INIT_BO_DEF     = 24'd100;
    localparam logic [23:0] MAX_BO_DEF      = 24'd30000;
    localparam logic [7:0]  MAX_RETRIES_DEF = 8'd5;
    localparam logic [8:0]  JITTER_DEF      = 9'd0;

    localparam logic [19:0] TOTAL_MAX = 20'hFFFFF;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;
    localparam logic [8:0]  RETRY_MAX = 9'd511;

    typedef enum logic [2:0] {
        REQ_ACQUIRE, REQ_RELEASE, REQ_READY, REQ_START_FAILED,
        REQ_LOST, REQ_QUIESCE_DONE, REQ_TICK, REQ_SHUTDOWN
    } req_t;

    typedef enum logic [2:0] {
        ACT_START, ACT_STOPPED, ACT_RETRY, ACT_REJECTED,
        ACT_QUIESCE, ACT_FORCE, ACT_REJECT_PENDING
    } action_t;

    typedef enum logic [2:0] {
        RSN_NONE, RSN_ZERO_ID, RSN_SHUTTING, RSN_START_TO,
        RSN_QUIESCE_TO, RSN_CALLER, RSN_FULL
    } reason_t;

    typedef enum logic [2:0] {
        CFG_KEEP_ALIVE, CFG_START_TO, CFG_QUIESCE_TO, CFG_INIT_BO,
        CFG_MAX_BO, CFG_MAX_RETRIES, CFG_JITTER
    } cfg_idx_t;

    typedef struct packed {
        action_t     action;
        logic [31:0] gen;
        logic [24:0] delay;
        reason_t     reason;
        logic [7:0]  diag;
    } res_t;

    typedef struct packed {
        logic scan;
        logic wr_en;
        logic set_valid;
        logic clr_valid;
        logic clr_all;
    } lk_ctl_t;

    typedef struct packed {
        logic done;
        logic hit;
        logic has_free;
    } lk_sts_t;

    function automatic res_t mk_res(action_t a, logic [31:0] g, logic [24:0] d,
                                    reason_t r, logic [7:0] dg);
        res_t x;
        x.action = a;
        x.gen    = g;
        x.delay  = d;
        x.reason = r;
        x.diag   = (r == RSN_CALLER) ? dg : 8'd0;
        return x;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/llrc_lease_table.sv
`default_nettype none
// ---------------------------------------------------------------------------
// llrc_lease_table
// Lease table memory with per-slot valid bits and a one-slot-per-cycle scan.
// ---------------------------------------------------------------------------
module llrc_lease_table #(
    parameter int SLOTS = llrc_pkg::LEASE_SLOTS_DEF
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  llrc_pkg::lk_ctl_t    ctl,
    input  wire  [31:0]          id,
    input  wire  [SW-1:0]        wr_slot,
    input  wire  [15:0]          wr_count,
    output llrc_pkg::lk_sts_t    sts,
    output logic [SW-1:0]        hit_slot,
    output logic [15:0]          hit_count,
    output logic [SW-1:0]        free_slot
);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    typedef struct packed {
        logic [31:0] owner;
        logic [15:0] count;
    } entry_t;

    entry_t            mem [SLOTS];
    entry_t            rd_data_reg;
    logic              scan_reg;
    logic [CW-1:0]     issue_reg;
    logic              chk_valid_reg;
    logic [SW-1:0]     chk_slot_reg;
    logic [31:0]       id_reg;
    logic              hit_reg;
    logic [SW-1:0]     hit_slot_reg;
    logic [15:0]       hit_count_reg;
    logic              free_reg;
    logic [SW-1:0]     free_slot_reg;
    logic              done_reg;
    logic [SLOTS-1:0]  valid_reg;
    logic              rd_en;

    assign rd_en = scan_reg && (issue_reg < CW'(SLOTS));

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[issue_reg[SW-1:0]];
        end
        if (ctl.wr_en)
        begin
            mem[wr_slot] <= '{owner: id_reg, count: wr_count};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg      <= 1'b0;
            issue_reg     <= '0;
            chk_valid_reg <= 1'b0;
            chk_slot_reg  <= '0;
            id_reg        <= '0;
            hit_reg       <= 1'b0;
            hit_slot_reg  <= '0;
            hit_count_reg <= '0;
            free_reg      <= 1'b0;
            free_slot_reg <= '0;
            done_reg      <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            done_reg      <= 1'b0;
            chk_valid_reg <= 1'b0;
            if (ctl.scan)
            begin
                scan_reg  <= 1'b1;
                issue_reg <= '0;
                id_reg    <= id;
                hit_reg   <= 1'b0;
                free_reg  <= 1'b0;
            end
            else if (scan_reg)
            begin
                if (rd_en)
                begin
                    issue_reg     <= issue_reg + CW'(1);
                    chk_valid_reg <= 1'b1;
                    chk_slot_reg  <= issue_reg[SW-1:0];
                end
                else
                begin
                    scan_reg <= 1'b0;
                end
            end
            // compare stage on the registered read data
            if (chk_valid_reg)
            begin
                if (valid_reg[chk_slot_reg] && rd_data_reg.owner == id_reg)
                begin
                    hit_reg       <= 1'b1;
                    hit_slot_reg  <= chk_slot_reg;
                    hit_count_reg <= rd_data_reg.count;
                end
                else if (!valid_reg[chk_slot_reg] && !free_reg)
                begin
                    free_reg      <= 1'b1;
                    free_slot_reg <= chk_slot_reg;
                end
                if (chk_slot_reg == SW'(SLOTS - 1))
                begin
                    done_reg <= 1'b1;
                end
            end
            priority if (ctl.clr_all)
            begin
                valid_reg <= '0;
            end
            else if (ctl.set_valid)
            begin
                valid_reg[wr_slot] <= 1'b1;
            end
            else if (ctl.clr_valid)
            begin
                valid_reg[wr_slot] <= 1'b0;
            end
        end
    end

    assign sts.done     = done_reg;
    assign sts.hit      = hit_reg;
    assign sts.has_free = free_reg;
    assign hit_slot     = hit_slot_reg;
    assign hit_count    = hit_count_reg;
    assign free_slot    = free_slot_reg;

endmodule
`default_nettype wire

FILE: rtl/llrc_backoff.sv
`default_nettype none
// ---------------------------------------------------------------------------
// llrc_backoff
// Iterative exponential backoff with cap and rounded signed jitter.
// ---------------------------------------------------------------------------
module llrc_backoff (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    input  wire  [8:0]  retry_count,
    input  wire  [23:0] init_ms,
    input  wire  [23:0] max_ms,
    input  wire  [8:0]  jitter_ratio,
    input  wire  [8:0]  jitter_unit,
    output logic        done,
    output logic [24:0] delay_ms
);
    typedef enum logic [2:0] {BO_IDLE, BO_LOOP, BO_MUL1, BO_MUL2, BO_FIN} bo_st_t;

    bo_st_t      st_reg;
    logic [23:0] delay_reg;
    logic [23:0] cap_reg;
    logic [8:0]  exp_reg;
    logic [8:0]  i_reg;
    logic [8:0]  r_reg;
    logic [8:0]  s_abs_reg;
    logic        neg_reg;
    logic [32:0] p1_reg;
    logic [41:0] mag_reg;
    logic        done_reg;
    logic [24:0] out_reg;

    logic [8:0]  ju_c;
    logic [9:0]  ju2;
    logic [42:0] rnd;
    logic [24:0] q;

    assign ju_c = (jitter_unit > 9'd256) ? 9'd256 : jitter_unit;
    assign ju2  = {ju_c, 1'b0};
    assign rnd  = 43'(mag_reg) + 43'd32768;
    assign q    = rnd[40:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= BO_IDLE;
            done_reg  <= 1'b0;
            delay_reg <= '0;
            cap_reg   <= '0;
            exp_reg   <= '0;
            i_reg     <= '0;
            r_reg     <= '0;
            s_abs_reg <= '0;
            neg_reg   <= 1'b0;
            p1_reg    <= '0;
            mag_reg   <= '0;
            out_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (st_reg)
                BO_IDLE:
                begin
                    if (start)
                    begin
                        delay_reg <= init_ms;
                        cap_reg   <= (max_ms < init_ms) ? init_ms : max_ms;
                        exp_reg   <= (retry_count == 9'd0) ? 9'd0 : retry_count - 9'd1;
                        i_reg     <= '0;
                        r_reg     <= (jitter_ratio > 9'd256) ? 9'd256 : jitter_ratio;
                        neg_reg   <= (ju_c < 9'd128);
                        s_abs_reg <= (ju_c < 9'd128) ? 9'(10'd256 - ju2)
                                                     : 9'(ju2 - 10'd256);
                        st_reg    <= BO_LOOP;
                    end
                end
                BO_LOOP:
                begin
                    if (i_reg < exp_reg && delay_reg < cap_reg)
                    begin
                        if (delay_reg > (cap_reg >> 1))
                        begin
                            delay_reg <= cap_reg;
                            st_reg    <= BO_MUL1;
                        end
                        else
                        begin
                            delay_reg <= {delay_reg[22:0], 1'b0};
                            i_reg     <= i_reg + 9'd1;
                        end
                    end
                    else
                    begin
                        st_reg <= BO_MUL1;
                    end
                end
                BO_MUL1:
                begin
                    p1_reg <= 33'(delay_reg) * 33'(r_reg);
                    st_reg <= BO_MUL2;
                end
                BO_MUL2:
                begin
                    mag_reg <= 42'(p1_reg) * 42'(s_abs_reg);
                    st_reg  <= BO_FIN;
                end
                BO_FIN:
                begin
                    if (neg_reg)
                    begin
                        out_reg <= (q > 25'(delay_reg)) ? 25'd0 : 25'(delay_reg) - q;
                    end
                    else
                    begin
                        out_reg <= 25'(delay_reg) + q;
                    end
                    done_reg <= 1'b1;
                    st_reg   <= BO_IDLE;
                end
                default:
                begin
                    st_reg <= BO_IDLE;
                end
            endcase
        end
    end

    assign done     = done_reg;
    assign delay_ms = out_reg;

endmodule
`default_nettype wire

FILE: rtl/lease_lifecycle_retry_controller_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lease_lifecycle_retry_controller_core
// Lease counting lifecycle controller with deadlines and retry backoff.
// ---------------------------------------------------------------------------
// usage:
//   request channel: drive the fields with start high; the request is taken at
//   a rising edge where start is high and busy is low. busy stays high until the
//   request ends; it falls in the same cycle as the final result is shown.
//   results: result_valid marks each result for one cycle; last flags the final
//   one. A request gives zero, one or two results, back to back.
//   config channel: cfg_ready is always high; a write lands at the edge where
//   cfg_valid is high. Write only while busy is low.
//   lookups: acquire and release scan the lease table one slot per cycle
//   through the memory read port; a retry adds the backoff unit, which doubles
//   the delay per retry up to the cap and then applies the jitter. One request
//   is in flight at a time.
//   reset: control state and config return to defaults, lease table empty.
//   the receiver cannot stall; results are never held.
// ---------------------------------------------------------------------------
module lease_lifecycle_retry_controller_core #(
    parameter int LEASE_SLOTS = llrc_pkg::LEASE_SLOTS_DEF,
    parameter int TIME_BITS   = llrc_pkg::TIME_BITS_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [2:0]  req_type,
    input  wire  [31:0] client_id,
    input  wire  [31:0] generation,
    input  wire  [31:0] now_ms,
    input  wire         loss_kind,
    input  wire  [7:0]  diag_code,
    input  wire  [8:0]  jitter_unit,
    output logic        result_valid,
    output logic [2:0]  action,
    output logic [31:0] action_generation,
    output logic [24:0] retry_delay_ms,
    output logic [2:0]  reason,
    output logic [7:0]  caller_diag,
    output logic        last,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [2:0]  cfg_index,
    input  wire  [23:0] cfg_data
);
    localparam int SW   = (LEASE_SLOTS > 1) ? $clog2(LEASE_SLOTS) : 1;
    localparam int NW   = (TIME_BITS > 32) ? TIME_BITS : 32;
    localparam int SUMW = ((TIME_BITS > 25) ? TIME_BITS : 25) + 1;
    localparam logic [TIME_BITS-1:0] TMAX = '1;

    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_SCAN, S_BKICK, S_BACK, S_OUT
    } fsm_t;

    typedef enum logic [2:0] {
        H_ABSENT, H_STARTING, H_READY, H_KEEPALIVE, H_QUIESCING, H_FAILED, H_STOPPED
    } host_t;

    // config registers
    logic [23:0] keep_reg, start_to_reg, quiesce_to_reg, init_bo_reg, max_bo_reg;
    logic [7:0]  max_retries_reg;
    logic [8:0]  jitter_reg;
    logic [23:0] keep_eff, start_eff, quiesce_eff, init_eff, max_eff;

    // lifecycle state
    fsm_t                 st_reg, st_next;
    host_t                host_reg, host_next;
    logic [TIME_BITS-1:0] dl_reg, dl_next;
    logic                 armed_reg, armed_next;
    logic [31:0]          gen_reg, gen_next;
    logic [8:0]           retry_reg, retry_next;
    logic                 shut_reg, shut_next;
    logic [19:0]          total_reg, total_next;
    llrc_pkg::res_t       res_reg [2];
    llrc_pkg::res_t       res_next [2];
    logic [1:0]           nres_reg, nres_next;
    logic                 out_idx_reg, out_idx_next;
    llrc_pkg::reason_t    frsn_reg, frsn_next;
    logic [7:0]           fdiag_reg, fdiag_next;
    llrc_pkg::res_t       out_reg, out_next;
    logic                 rv_reg, rv_next;
    logic                 last_reg, last_next;

    // latched request
    llrc_pkg::req_t       type_reg;
    logic [31:0]          id_reg;
    logic [31:0]          gin_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic                 loss_reg;
    logic [7:0]           diag_reg;
    logic [8:0]           ju_reg;
    logic [NW-1:0]        now_ext;

    // sub-unit links
    llrc_pkg::lk_ctl_t    lk_ctl;
    llrc_pkg::lk_sts_t    lk_sts;
    logic [SW-1:0]        lk_wr_slot, lk_hit_slot, lk_free_slot;
    logic [15:0]          lk_wr_count, lk_hit_count;
    logic                 bo_start, bo_done;
    logic [24:0]          bo_delay;

    // decision helpers
    logic                 bs, stp, fl, pre, gm, due, full;
    llrc_pkg::reason_t    srsn, frsn;
    logic [7:0]           sdiag, fdiag;
    logic [31:0]          gen_inc;
    logic [8:0]           rc_inc;
    logic [19:0]          tot_dec;

    function automatic logic [TIME_BITS-1:0] sat_add(logic [TIME_BITS-1:0] n,
                                                     logic [24:0] d);
        logic [SUMW-1:0] s;
        s = SUMW'(n) + SUMW'(d);
        return (s > SUMW'(TMAX)) ? TMAX : s[TIME_BITS-1:0];
    endfunction

    assign keep_eff    = (keep_reg != 24'd0) ? keep_reg : llrc_pkg::KEEP_ALIVE_DEF;
    assign start_eff   = (start_to_reg != 24'd0) ? start_to_reg : llrc_pkg::START_TO_DEF;
    assign quiesce_eff = (quiesce_to_reg != 24'd0) ? quiesce_to_reg
                                                   : llrc_pkg::QUIESCE_TO_DEF;
    assign init_eff    = (init_bo_reg != 24'd0) ? init_bo_reg : llrc_pkg::INIT_BO_DEF;
    assign max_eff     = (max_bo_reg != 24'd0) ? max_bo_reg : init_eff;
    assign now_ext     = NW'(now_ms);
    assign cfg_ready   = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_reg        <= llrc_pkg::KEEP_ALIVE_DEF;
            start_to_reg    <= llrc_pkg::START_TO_DEF;
            quiesce_to_reg  <= llrc_pkg::QUIESCE_TO_DEF;
            init_bo_reg     <= llrc_pkg::INIT_BO_DEF;
            max_bo_reg      <= llrc_pkg::MAX_BO_DEF;
            max_retries_reg <= llrc_pkg::MAX_RETRIES_DEF;
            jitter_reg      <= llrc_pkg::JITTER_DEF;
        end
        else if (cfg_valid)
        begin
            case (llrc_pkg::cfg_idx_t'(cfg_index))
                llrc_pkg::CFG_KEEP_ALIVE:  keep_reg        <= cfg_data;
                llrc_pkg::CFG_START_TO:    start_to_reg    <= cfg_data;
                llrc_pkg::CFG_QUIESCE_TO:  quiesce_to_reg  <= cfg_data;
                llrc_pkg::CFG_INIT_BO:     init_bo_reg     <= cfg_data;
                llrc_pkg::CFG_MAX_BO:      max_bo_reg      <= cfg_data;
                llrc_pkg::CFG_MAX_RETRIES: max_retries_reg <= cfg_data[7:0];
                llrc_pkg::CFG_JITTER:      jitter_reg      <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == S_IDLE && start)
        begin
            type_reg <= llrc_pkg::req_t'(req_type);
            id_reg   <= client_id;
            gin_reg  <= generation;
            now_reg  <= now_ext[TIME_BITS-1:0];
            loss_reg <= loss_kind;
            diag_reg <= diag_code;
            ju_reg   <= jitter_unit;
        end
    end

    assign gen_inc = (gen_reg + 32'd1 == 32'd0) ? 32'd1 : gen_reg + 32'd1;
    assign rc_inc  = (retry_reg < llrc_pkg::RETRY_MAX) ? retry_reg + 9'd1 : retry_reg;
    assign tot_dec = (total_reg != 20'd0) ? total_reg - 20'd1 : 20'd0;
    assign gm      = (gin_reg != 32'd0) && (gin_reg == gen_reg);
    assign due     = armed_reg && (now_reg >= dl_reg);
    assign full    = (total_reg >= llrc_pkg::TOTAL_MAX)
                   || (!lk_sts.hit && !lk_sts.has_free)
                   || (lk_sts.hit && lk_hit_count >= llrc_pkg::COUNT_MAX);

    always_comb
    begin
        st_next      = st_reg;
        host_next    = host_reg;
        dl_next      = dl_reg;
        armed_next   = armed_reg;
        gen_next     = gen_reg;
        retry_next   = retry_reg;
        shut_next    = shut_reg;
        total_next   = total_reg;
        res_next     = res_reg;
        nres_next    = nres_reg;
        out_idx_next = out_idx_reg;
        frsn_next    = frsn_reg;
        fdiag_next   = fdiag_reg;
        out_next     = out_reg;
        rv_next      = 1'b0;
        last_next    = 1'b0;
        lk_ctl       = '0;
        lk_wr_slot   = '0;
        lk_wr_count  = '0;
        bo_start     = 1'b0;
        bs           = 1'b0;
        stp          = 1'b0;
        fl           = 1'b0;
        pre          = 1'b0;
        srsn         = llrc_pkg::RSN_NONE;
        sdiag        = 8'd0;
        frsn         = llrc_pkg::RSN_NONE;
        fdiag        = 8'd0;

        unique case (st_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    st_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                st_next      = S_OUT;
                nres_next    = 2'd0;
                out_idx_next = 1'b0;
                unique case (type_reg)
                    llrc_pkg::REQ_ACQUIRE:
                    begin
                        if (id_reg == 32'd0)
                        begin
                            res_next[0] = llrc_pkg::mk_res(llrc_pkg::ACT_REJECTED, gen_reg,
                                25'd0, llrc_pkg::RSN_ZERO_ID, 8'd0);
                            nres_next = 2'd1;
                        end
                        else if (shut_reg)
                        begin
                            res_next[0] = llrc_pkg::mk_res(llrc_pkg::ACT_REJECTED, gen_reg,
                                25'd0, llrc_pkg::RSN_SHUTTING, 8'd0);
                            nres_next = 2'd1;
                        end
                        else
                        begin
                            lk_ctl.scan = 1'b1;
                            st_next     = S_SCAN;
                        end
                    end
                    llrc_pkg::REQ_RELEASE:
                    begin
                        lk_ctl.scan = 1'b1;
                        st_next     = S_SCAN;
                    end
                    llrc_pkg::REQ_READY:
                    begin
                        if (host_reg == H_STARTING && gm)
                        begin
                            retry_next = 9'd0;
                            priority if (shut_reg)
                            begin
                                host_next   = H_QUIESCING;
                                dl_next     = sat_add(now_reg, 25'(quiesce_eff));
                                armed_next  = 1'b1;
                                res_next[0] = llrc_pkg::mk_res(llrc_pkg::ACT_QUIESCE, gen_reg,
                                    25'd0, llrc_pkg::RSN_NONE, 8'd0);
                                nres_next   = 2'd1;
                            end
                            else if (total_reg != 20'd0)
                            begin
                                host_next  = H_READY;
                                dl_next    = '0;
                                armed_next = 1'b0;
                            end
                            else
                            begin
                                host_next  = H_KEEPALIVE;
                                dl_next    = sat_add(now_reg, 25'(keep_eff));
                                armed_next = 1'b1;
                            end
                        end
                    end
                    llrc_pkg::REQ_START_FAILED:
                    begin
                        if (host_reg == H_STARTING && gm)
                        begin
                            fl    = 1'b1;
                            frsn  = llrc_pkg::RSN_CALLER;
                            fdiag = diag_reg;
                        end
                    end
                    llrc_pkg::REQ_LOST:
                    begin
                        if (gm && (host_reg == H_STARTING || host_reg == H_READY
                                   || host_reg == H_KEEPALIVE || host_reg == H_QUIESCING))
                        begin
                            res_next[0] = llrc_pkg::mk_res(llrc_pkg::ACT_REJECT_PENDING,
                                gen_reg, 25'd0, llrc_pkg::RSN_CALLER, diag_reg);
                            nres_next = 2'd1;
                            pre       = 1'b1;
                            if (loss_reg)
                            begin
                                host_next  = shut_reg ? H_STOPPED : H_ABSENT;
                                dl_next    = '0;
                                armed_next = 1'b0;
                                retry_next = 9'd0;
                                stp        = shut_reg;
                            end
                            else
                            begin
                                fl    = 1'b1;
                                frsn  = llrc_pkg::RSN_CALLER;
                                fdiag = diag_reg;
                            end
                        end
                    end
                    llrc_pkg::REQ_QUIESCE_DONE:
                    begin
                        if (host_reg == H_QUIESCING && gm)
                        begin
                            if (!shut_reg && total_reg != 20'd0)
                            begin
                                retry_next = 9'd0;
                                bs         = 1'b1;
                            end
                            else
                            begin
                                stp = 1'b1;
                            end
                        end
                    end
                    llrc_pkg::REQ_TICK:
                    begin
                        if (due)
                        begin
                            unique case (host_reg)
                                H_STARTING:
                                begin
                                    res_next[0] = llrc_pkg::mk_res(llrc_pkg::ACT_FORCE,
                                        gen_reg, 25'd0, llrc_pkg::RSN_START_TO, 8'd0);
                                    nres_next = 2'd1;
                                    pre       = 1'b1;
                                    fl        = 1'b1;
                                    frsn      = llrc_pkg::RSN_START_TO;
                                end
                                H_KEEPALIVE:
                                begin
                                    host_next   = H_QUIESCING;
                                    dl_next     = sat_add(now_reg, 25'(quiesce_eff));
                                    armed_next  = 1'b1;
                                    res_next[0] = llrc_pkg::mk_res(llrc_pkg::ACT_QUIESCE,
                                        gen_reg, 25'd0, llrc_pkg::RSN_NONE, 8'd0);
                                    nres_next   = 2'd1;
                                end
                                H_FAILED:
                                begin
                                    if (shut_reg || total_reg == 20'd0)
                                    begin
                                        stp = 1'b1;
                                    end
                                    else
                                    begin
                                        bs = 1'b1;
                                    end
                                end
                                H_QUIESCING:
                                begin
                                    res_next[0] = llrc_pkg::mk_res(llrc_pkg::ACT_FORCE,
                                        gen_reg, 25'd0, llrc_pkg::RSN_QUIESCE_TO, 8'd0);
                                    nres_next = 2'd1;
                                    pre       = 1'b1;
                                    if (!shut_reg && total_reg != 20'd0)
                                    begin
                                        bs = 1'b1;
                                    end
                                    else
                                    begin
                                        stp  = 1'b1;
                                        srsn = llrc_pkg::RSN_QUIESCE_TO;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                    llrc_pkg::REQ_SHUTDOWN:
                    begin
                        if (!shut_reg)
                        begin
                            shut_next      = 1'b1;
                            lk_ctl.clr_all = 1'b1;
                            total_next     = 20'd0;
                            unique case (host_reg)
                                H_STARTING, H_READY, H_KEEPALIVE:
                                begin
                                    host_next   = H_QUIESCING;
                                    dl_next     = sat_add(now_reg, 25'(quiesce_eff));
                                    armed_next  = 1'b1;
                                    res_next[0] = llrc_pkg::mk_res(llrc_pkg::ACT_QUIESCE,
                                        gen_reg, 25'd0, llrc_pkg::RSN_NONE, 8'd0);
                                    nres_next   = 2'd1;
                                end
                                H_QUIESCING: ;
                                default:
                                begin
                                    stp = 1'b1;
                                end
                            endcase
                        end
                    end
                    default: ;
                endcase
            end
            S_SCAN:
            begin
                if (lk_sts.done)
                begin
                    st_next = S_OUT;
                    if (type_reg == llrc_pkg::REQ_ACQUIRE)
                    begin
                        if (full)
                        begin
                            res_next[0] = llrc_pkg::mk_res(llrc_pkg::ACT_REJECTED, gen_reg,
                                25'd0, llrc_pkg::RSN_FULL, 8'd0);
                            nres_next = 2'd1;
                        end
                        else
                        begin
                            lk_ctl.wr_en     = 1'b1;
                            lk_ctl.set_valid = !lk_sts.hit;
                            lk_wr_slot       = lk_sts.hit ? lk_hit_slot : lk_free_slot;
                            lk_wr_count      = lk_sts.hit ? lk_hit_count + 16'd1 : 16'd1;
                            total_next       = total_reg + 20'd1;
                            unique case (host_reg)
                                H_ABSENT, H_STOPPED:
                                begin
                                    retry_next = 9'd0;
                                    bs         = 1'b1;
                                end
                                H_KEEPALIVE:
                                begin
                                    host_next  = H_READY;
                                    dl_next    = '0;
                                    armed_next = 1'b0;
                                end
                                H_FAILED:
                                begin
                                    bs = !armed_reg || (now_reg >= dl_reg);
                                end
                                default: ;
                            endcase
                        end
                    end
                    else if (lk_sts.hit)
                    begin
                        lk_ctl.wr_en     = 1'b1;
                        lk_ctl.clr_valid = (lk_hit_count == 16'd1);
                        lk_wr_slot       = lk_hit_slot;
                        lk_wr_count      = lk_hit_count - 16'd1;
                        total_next       = tot_dec;
                        if (tot_dec == 20'd0)
                        begin
                            if (host_reg == H_READY)
                            begin
                                host_next  = H_KEEPALIVE;
                                dl_next    = sat_add(now_reg, 25'(keep_eff));
                                armed_next = 1'b1;
                            end
                            else if (host_reg == H_FAILED)
                            begin
                                host_next  = H_ABSENT;
                                dl_next    = '0;
                                armed_next = 1'b0;
                                retry_next = 9'd0;
                            end
                        end
                    end
                end
            end
            S_BKICK:
            begin
                bo_start = 1'b1;
                st_next  = S_BACK;
            end
            S_BACK:
            begin
                if (bo_done)
                begin
                    host_next  = H_FAILED;
                    dl_next    = sat_add(now_reg, bo_delay);
                    armed_next = 1'b1;
                    res_next[nres_reg[0]] = llrc_pkg::mk_res(llrc_pkg::ACT_RETRY, gen_reg,
                        bo_delay, frsn_reg, fdiag_reg);
                    nres_next = nres_reg + 2'd1;
                    st_next   = S_OUT;
                end
            end
            S_OUT:
            begin
                if (nres_reg == 2'd0)
                begin
                    st_next = S_IDLE;
                end
                else
                begin
                    rv_next   = 1'b1;
                    out_next  = res_reg[out_idx_reg];
                    last_next = ({1'b0, out_idx_reg} + 2'd1 == nres_reg);
                    if (last_next)
                    begin
                        st_next      = S_IDLE;
                        out_idx_next = 1'b0;
                    end
                    else
                    begin
                        out_idx_next = 1'b1;
                    end
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase

        // shared tails: start, stop and failure handling
        if (bs)
        begin
            gen_next      = gen_inc;
            host_next     = H_STARTING;
            dl_next       = sat_add(now_reg, 25'(start_eff));
            armed_next    = 1'b1;
            res_next[pre] = llrc_pkg::mk_res(llrc_pkg::ACT_START, gen_inc, 25'd0,
                                             llrc_pkg::RSN_NONE, 8'd0);
            nres_next     = {1'b0, pre} + 2'd1;
        end
        if (fl)
        begin
            priority if (shut_reg)
            begin
                stp   = 1'b1;
                srsn  = frsn;
                sdiag = fdiag;
            end
            else if (total_reg == 20'd0)
            begin
                host_next  = H_ABSENT;
                dl_next    = '0;
                armed_next = 1'b0;
                retry_next = 9'd0;
            end
            else if (rc_inc > {1'b0, max_retries_reg})
            begin
                retry_next = rc_inc;
                stp        = 1'b1;
                srsn       = frsn;
                sdiag      = fdiag;
            end
            else
            begin
                retry_next = rc_inc;
                frsn_next  = frsn;
                fdiag_next = fdiag;
                st_next    = S_BKICK;
            end
        end
        if (stp)
        begin
            host_next     = H_STOPPED;
            dl_next       = '0;
            armed_next    = 1'b0;
            res_next[pre] = llrc_pkg::mk_res(llrc_pkg::ACT_STOPPED, gen_reg, 25'd0,
                                             srsn, sdiag);
            nres_next     = {1'b0, pre} + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= S_IDLE;
            host_reg    <= H_ABSENT;
            dl_reg      <= '0;
            armed_reg   <= 1'b0;
            gen_reg     <= '0;
            retry_reg   <= '0;
            shut_reg    <= 1'b0;
            total_reg   <= '0;
            nres_reg    <= '0;
            out_idx_reg <= 1'b0;
            rv_reg      <= 1'b0;
            last_reg    <= 1'b0;
            frsn_reg    <= llrc_pkg::RSN_NONE;
            fdiag_reg   <= '0;
        end
        else
        begin
            st_reg      <= st_next;
            host_reg    <= host_next;
            dl_reg      <= dl_next;
            armed_reg   <= armed_next;
            gen_reg     <= gen_next;
            retry_reg   <= retry_next;
            shut_reg    <= shut_next;
            total_reg   <= total_next;
            nres_reg    <= nres_next;
            out_idx_reg <= out_idx_next;
            rv_reg      <= rv_next;
            last_reg    <= last_next;
            frsn_reg    <= frsn_next;
            fdiag_reg   <= fdiag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        out_reg <= out_next;
    end

    llrc_lease_table #(
        .SLOTS(LEASE_SLOTS)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (lk_ctl),
        .id        (id_reg),
        .wr_slot   (lk_wr_slot),
        .wr_count  (lk_wr_count),
        .sts       (lk_sts),
        .hit_slot  (lk_hit_slot),
        .hit_count (lk_hit_count),
        .free_slot (lk_free_slot)
    );

    llrc_backoff u_backoff (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (bo_start),
        .retry_count  (retry_reg),
        .init_ms      (init_eff),
        .max_ms       (max_eff),
        .jitter_ratio (jitter_reg),
        .jitter_unit  (ju_reg),
        .done         (bo_done),
        .delay_ms     (bo_delay)
    );

    assign busy              = (st_reg != S_IDLE);
    assign result_valid      = rv_reg;
    assign action            = out_reg.action;
    assign action_generation = out_reg.gen;
    assign retry_delay_ms    = out_reg.delay;
    assign reason            = out_reg.reason;
    assign caller_diag       = out_reg.diag;
    assign last              = last_reg;

endmodule
`default_nettype wire

FILE: rtl/llrc_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// llrc_checker
// Port-level checks of the controller request and result behavior.
// ---------------------------------------------------------------------------
module llrc_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        start,
    input wire        busy,
    input wire        result_valid,
    input wire [2:0]  action,
    input wire [24:0] retry_delay_ms,
    input wire [2:0]  reason,
    input wire [7:0]  caller_diag,
    input wire        last
);
    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request taken but busy not raised");

    a_res_in_req: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy || $past(busy))
        else $error("result outside a request");

    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |=> result_valid)
        else $error("second result missing");

    a_delay: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && action != llrc_pkg::ACT_RETRY |-> retry_delay_ms == 25'd0)
        else $error("delay on a non-retry result");

    a_diag: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && reason != llrc_pkg::RSN_CALLER |-> caller_diag == 8'd0)
        else $error("diag without caller reason");

endmodule

bind lease_lifecycle_retry_controller_core llrc_checker u_llrc_checker (.*);
`default_nettype wire
